// ===== hdl/sqd_pkg.sv =====
// shared types and constants for the shortest-queue dispatch block
// no dependencies; used by the interfaces and every module of the block
package sqd_pkg;

    localparam int NUM_QUEUES = 4;
    localparam int QI_W       = 2;
    localparam int DATA_W     = 8;
    localparam int ENTRY_W    = 16;
    localparam int LIMIT_W    = 5;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    localparam logic REQ_ENQ   = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // register index is taken from the word-address bit of paddr
    localparam logic REG_QUEUE_LIMIT = 1'b0;

    typedef struct packed {
        logic                kind;
        logic [QI_W-1:0]     qidx;
        logic                success;
        logic [DATA_W-1:0]   prio;
        logic [DATA_W-1:0]   value;
        logic                last;
    } t_res;

    typedef struct packed {
        logic we;
        logic re;
    } t_ram_cmd;

endpackage

// ===== hdl/sqd_ifs.sv =====
// request and result channel interfaces of the shortest-queue dispatch block
// depends on sqd_pkg
interface sqd_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [sqd_pkg::DATA_W-1:0]  entry_priority;
    logic [sqd_pkg::DATA_W-1:0]  entry_value;

    modport source (output valid, output req_type, output entry_priority,
                    output entry_value, input ready);
    modport sink   (input valid, input req_type, input entry_priority,
                    input entry_value, output ready);
endinterface

interface sqd_res_if;
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic [sqd_pkg::QI_W-1:0]    queue_index;
    logic                        success;
    logic [sqd_pkg::DATA_W-1:0]  out_priority;
    logic [sqd_pkg::DATA_W-1:0]  out_value;
    logic                        last_of_run;

    modport source (output valid, output result_kind, output queue_index,
                    output success, output out_priority, output out_value,
                    output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input queue_index,
                    input success, input out_priority, input out_value,
                    input last_of_run, output ready);
endinterface

// ===== hdl/shortest_queue_dispatch_priority_drain_top.sv =====
// top level of the shortest-queue dispatch block with priority-head drain
// depends on sqd_pkg, sqd_ifs, sqd_entry_ram, sqd_apb_regs, sqd_ctrl
//
// usage:
//   i_req carries one request: req_type 0 enqueues (entry_priority, entry_value)
//   into the least-filled queue starting from a rotating slot; req_type 1 pops
//   the two highest-priority queue heads.
//   o_res returns one report per enqueue and two per drain, the final one with
//   last_of_run set. valid/ready handshake on both channels.
//   apb register 0 (byte address 0) holds queue_limit, reset 16.
// sequence:
//   a request is taken only while the sequencer is idle. an enqueue runs a
//   4-step fill count scan, one limit check, one write and one idle step.
//   a drain reads each queue head from the entry store when the queue holds
//   entries, with one compare then and a second one when two candidates are
//   held and the head does not beat the best; then two pops and one idle
//   step follow. the single store port and comparator serialize the steps.
// reset and stall:
//   synchronous reset empties all queues and needs no clearing pass. a result
//   stays in the output register while o_res.ready is low; the sequencer waits
//   before writing the next result, and then no request is taken.
module shortest_queue_dispatch_priority_drain_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sqd_req_if.sink                       i_req,
    sqd_res_if.source                     o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sqd_pkg::APB_AW-1:0]    paddr,
    input  logic [sqd_pkg::APB_DW-1:0]    pwdata,
    output logic [sqd_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int STORE_DEPTH = sqd_pkg::NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    logic [sqd_pkg::LIMIT_W-1:0]  queue_limit;
    sqd_pkg::t_ram_cmd            ram_cmd;
    logic [ADDR_W-1:0]            ram_addr;
    logic [sqd_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [sqd_pkg::ENTRY_W-1:0]  ram_rdata;

    sqd_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_queue_limit (queue_limit)
    );

    sqd_entry_ram #(
        .DEPTH (STORE_DEPTH),
        .AW    (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_cmd   (ram_cmd),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    sqd_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (ADDR_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .o_res         (o_res),
        .i_queue_limit (queue_limit),
        .o_ram_cmd     (ram_cmd),
        .o_ram_addr    (ram_addr),
        .o_ram_wdata   (ram_wdata),
        .i_ram_rdata   (ram_rdata)
    );

endmodule

// ===== hdl/sqd_entry_ram.sv =====
// entry store: single-port memory with registered read data
// depends on sqd_pkg
module sqd_entry_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                          i_clk,
    input  sqd_pkg::t_ram_cmd             i_cmd,
    input  logic [AW-1:0]                 i_addr,
    input  logic [sqd_pkg::ENTRY_W-1:0]   i_wdata,
    output logic [sqd_pkg::ENTRY_W-1:0]   o_rdata
);

    logic [sqd_pkg::ENTRY_W-1:0] r_mem [DEPTH];
    logic [sqd_pkg::ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_cmd.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sqd_apb_regs.sv =====
// apb configuration register: queue_limit
// depends on sqd_pkg
module sqd_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sqd_pkg::APB_AW-1:0]    paddr,
    input  logic [sqd_pkg::APB_DW-1:0]    pwdata,
    output logic [sqd_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output logic [sqd_pkg::LIMIT_W-1:0]   o_queue_limit
);

    logic [sqd_pkg::LIMIT_W-1:0] r_queue_limit;
    logic                        hit;

    assign hit = (paddr[sqd_pkg::APB_AW-1] == sqd_pkg::REG_QUEUE_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_limit <= sqd_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && hit) begin
            r_queue_limit <= pwdata[sqd_pkg::LIMIT_W-1:0];
        end
    end

    assign prdata        = hit ? sqd_pkg::APB_DW'(r_queue_limit) : '0;
    assign pready        = 1'b1;
    assign o_queue_limit = r_queue_limit;

endmodule

// ===== hdl/sqd_ctrl.sv =====
// sequencer with one shared comparator: queue selection, fill counts, pointers
// depends on sqd_pkg and sqd_ifs; drives the entry store address and command
module sqd_ctrl #(
    parameter int QUEUE_DEPTH = 16,
    parameter int AW          = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sqd_req_if.sink                       i_req,
    sqd_res_if.source                     o_res,
    input  logic [sqd_pkg::LIMIT_W-1:0]   i_queue_limit,
    output sqd_pkg::t_ram_cmd             o_ram_cmd,
    output logic [AW-1:0]                 o_ram_addr,
    output logic [sqd_pkg::ENTRY_W-1:0]   o_ram_wdata,
    input  logic [sqd_pkg::ENTRY_W-1:0]   i_ram_rdata
);

    localparam int NQ    = sqd_pkg::NUM_QUEUES;
    localparam int QI_W  = sqd_pkg::QI_W;
    localparam int DW    = sqd_pkg::DATA_W;
    localparam int EW    = sqd_pkg::ENTRY_W;
    localparam int FC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SUM_W = FC_W + 1;
    localparam int CMP_W = (FC_W > DW) ? FC_W : DW;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ENQ_SCAN = 4'd1;
    localparam logic [3:0] S_ENQ_CHK  = 4'd2;
    localparam logic [3:0] S_ENQ_DO   = 4'd3;
    localparam logic [3:0] S_DRN_RD   = 4'd4;
    localparam logic [3:0] S_DRN_BEST = 4'd5;
    localparam logic [3:0] S_DRN_SEC  = 4'd6;
    localparam logic [3:0] S_POP1     = 4'd7;
    localparam logic [3:0] S_POP2     = 4'd8;

    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [AW-1:0]    DEPTH_A = AW'(QUEUE_DEPTH);
    localparam logic [QI_W-1:0]  IDX_TOP = QI_W'(NQ - 1);

    logic [3:0]         r_state, n_state;
    logic [FC_W-1:0]    r_fill [NQ];
    logic [PTR_W-1:0]   r_rp   [NQ];
    logic [QI_W-1:0]    r_slot;
    logic [QI_W-1:0]    r_idx;
    logic [QI_W-1:0]    r_target;
    logic [FC_W-1:0]    r_minc;
    logic [DW-1:0]      r_prio;
    logic [DW-1:0]      r_value;
    logic               r_ok;
    logic               r_has_best;
    logic               r_has_sec;
    logic [QI_W-1:0]    r_best_q;
    logic [QI_W-1:0]    r_sec_q;
    logic [EW-1:0]      r_best_e;
    logic [EW-1:0]      r_sec_e;
    logic               r_out_valid;
    sqd_pkg::t_res      r_out;

    logic [QI_W-1:0]    sel_q;
    logic [FC_W-1:0]    fill_sel;
    logic [PTR_W-1:0]   rp_sel;
    logic [PTR_W-1:0]   rp_next;
    logic [SUM_W-1:0]   wr_sum;
    logic [SUM_W-1:0]   wr_wrap;
    logic [PTR_W-1:0]   wr_pos;
    logic [CMP_W-1:0]   lim;
    logic [CMP_W-1:0]   cmp_a, cmp_b;
    logic               cmp_gt;
    logic               out_free;
    logic               out_load;
    logic               accept;
    logic               last_idx;
    logic               take_best;
    logic               take_sec;
    sqd_pkg::t_res      pop_res;

    assign accept   = i_req.valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || o_res.ready;
    assign out_load = out_free
                    && (r_state == S_ENQ_DO || r_state == S_POP1 || r_state == S_POP2);
    assign last_idx = (r_idx == IDX_TOP);

    // one queue selected per cycle for the fill count and read pointer
    always_comb begin
        unique case (r_state)
            S_IDLE:                          sel_q = r_slot;
            S_ENQ_SCAN, S_DRN_RD:            sel_q = r_idx;
            S_ENQ_CHK, S_ENQ_DO:             sel_q = r_target;
            S_POP1:                          sel_q = r_best_q;
            S_POP2:                          sel_q = r_sec_q;
            default:                         sel_q = r_idx;
        endcase
    end

    assign fill_sel = r_fill[sel_q];
    assign rp_sel   = r_rp[sel_q];
    assign rp_next  = (rp_sel == PTR_TOP) ? '0 : rp_sel + 1'b1;

    assign wr_sum  = SUM_W'(rp_sel) + SUM_W'(fill_sel);
    assign wr_wrap = (wr_sum >= DEPTH_S) ? wr_sum - DEPTH_S : wr_sum;
    assign wr_pos  = wr_wrap[PTR_W-1:0];

    assign lim = (CMP_W'(i_queue_limit) > DEPTH_C) ? DEPTH_C : CMP_W'(i_queue_limit);

    // shared comparator
    always_comb begin
        unique case (r_state)
            S_ENQ_SCAN: begin
                cmp_a = CMP_W'(r_minc);
                cmp_b = CMP_W'(fill_sel);
            end
            S_ENQ_CHK: begin
                cmp_a = lim;
                cmp_b = CMP_W'(fill_sel);
            end
            S_DRN_BEST: begin
                cmp_a = CMP_W'(i_ram_rdata[EW-1:DW]);
                cmp_b = CMP_W'(r_best_e[EW-1:DW]);
            end
            S_DRN_SEC: begin
                cmp_a = CMP_W'(i_ram_rdata[EW-1:DW]);
                cmp_b = CMP_W'(r_sec_e[EW-1:DW]);
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_gt    = cmp_a > cmp_b;
    assign take_best = !r_has_best || cmp_gt;
    assign take_sec  = !r_has_sec;

    always_comb begin
        o_ram_cmd.we = (r_state == S_ENQ_DO) && out_free && r_ok;
        o_ram_cmd.re = (r_state == S_DRN_RD) && (fill_sel != '0);
        o_ram_addr   = AW'(sel_q) * DEPTH_A
                     + ((r_state == S_ENQ_DO) ? AW'(wr_pos) : AW'(rp_sel));
        o_ram_wdata  = {r_prio, r_value};
    end

    always_comb begin
        pop_res.kind    = sqd_pkg::KIND_DEQ;
        pop_res.qidx    = '0;
        pop_res.success = 1'b0;
        pop_res.prio    = '0;
        pop_res.value   = '0;
        pop_res.last    = (r_state == S_POP2);
        if (r_state == S_POP1 && r_has_best) begin
            pop_res.qidx    = r_best_q;
            pop_res.success = 1'b1;
            pop_res.prio    = r_best_e[EW-1:DW];
            pop_res.value   = r_best_e[DW-1:0];
        end else if (r_state == S_POP2 && r_has_sec) begin
            pop_res.qidx    = r_sec_q;
            pop_res.success = 1'b1;
            pop_res.prio    = r_sec_e[EW-1:DW];
            pop_res.value   = r_sec_e[DW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_req.req_type == sqd_pkg::REQ_DRAIN) ? S_DRN_RD : S_ENQ_SCAN;
                end
            end
            S_ENQ_SCAN: begin
                if (last_idx) begin
                    n_state = S_ENQ_CHK;
                end
            end
            S_ENQ_CHK:  n_state = S_ENQ_DO;
            S_ENQ_DO: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DRN_RD: begin
                if (fill_sel != '0) begin
                    n_state = S_DRN_BEST;
                end else if (last_idx) begin
                    n_state = S_POP1;
                end
            end
            S_DRN_BEST: begin
                if (take_best || take_sec) begin
                    n_state = last_idx ? S_POP1 : S_DRN_RD;
                end else begin
                    n_state = S_DRN_SEC;
                end
            end
            S_DRN_SEC:  n_state = last_idx ? S_POP1 : S_DRN_RD;
            S_POP1: begin
                if (out_free) begin
                    n_state = S_POP2;
                end
            end
            S_POP2: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_idx       <= '0;
            r_target    <= '0;
            r_best_q    <= '0;
            r_sec_q     <= '0;
            r_out_valid <= 1'b0;
            r_has_best  <= 1'b0;
            r_has_sec   <= 1'b0;
            for (int q = 0; q < NQ; q++) begin
                r_fill[q] <= '0;
                r_rp[q]   <= '0;
            end
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_prio     <= i_req.entry_priority;
                        r_value    <= i_req.entry_value;
                        r_idx      <= '0;
                        r_target   <= r_slot;
                        r_minc     <= fill_sel;
                        r_has_best <= 1'b0;
                        r_has_sec  <= 1'b0;
                    end
                end
                S_ENQ_SCAN: begin
                    if (cmp_gt) begin
                        r_minc   <= fill_sel;
                        r_target <= r_idx;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_ENQ_CHK: begin
                    r_ok <= cmp_gt;
                end
                S_ENQ_DO: begin
                    if (out_free) begin
                        r_slot <= r_slot + 1'b1;
                        if (r_ok) begin
                            r_fill[r_target] <= fill_sel + 1'b1;
                        end
                        r_out.kind    <= sqd_pkg::KIND_ENQ;
                        r_out.qidx    <= r_target;
                        r_out.success <= r_ok;
                        r_out.prio    <= '0;
                        r_out.value   <= '0;
                        r_out.last    <= 1'b1;
                    end
                end
                S_DRN_RD: begin
                    if (fill_sel == '0) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DRN_BEST: begin
                    if (take_best) begin
                        r_sec_q    <= r_best_q;
                        r_sec_e    <= r_best_e;
                        r_has_sec  <= r_has_best;
                        r_best_q   <= r_idx;
                        r_best_e   <= i_ram_rdata;
                        r_has_best <= 1'b1;
                        r_idx      <= r_idx + 1'b1;
                    end else if (take_sec) begin
                        r_sec_q   <= r_idx;
                        r_sec_e   <= i_ram_rdata;
                        r_has_sec <= 1'b1;
                        r_idx     <= r_idx + 1'b1;
                    end
                end
                S_DRN_SEC: begin
                    if (cmp_gt) begin
                        r_sec_q <= r_idx;
                        r_sec_e <= i_ram_rdata;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_POP1, S_POP2: begin
                    if (out_free) begin
                        if (pop_res.success) begin
                            r_fill[sel_q] <= fill_sel - 1'b1;
                            r_rp[sel_q]   <= rp_next;
                        end
                        r_out <= pop_res;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.result_kind  = r_out.kind;
    assign o_res.queue_index  = r_out.qidx;
    assign o_res.success      = r_out.success;
    assign o_res.out_priority = r_out.prio;
    assign o_res.out_value    = r_out.value;
    assign o_res.last_of_run  = r_out.last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_sel <= FC_W'(QUEUE_DEPTH))
        else $error("fill count above queue depth");

    a_first_is_deq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.last |-> r_out.kind == sqd_pkg::KIND_DEQ)
        else $error("non-final result that is not a dequeue report");

    a_empty_pop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == sqd_pkg::KIND_DEQ && !r_out.success
        |-> r_out.qidx == '0 && r_out.prio == '0 && r_out.value == '0)
        else $error("failed pop carries nonzero fields");

    a_pop_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP2 |-> $past(r_state) == S_POP1 || $past(r_state) == S_POP2)
        else $error("second pop without first pop");

endmodule
